### rtl/ln_pkg.sv
`timescale 1ns / 1ps
// Layer normalisation: shared types and fixed constants.
// No dependencies; used by ln_ctrl, ln_datapath and layer_normalization.
package ln_pkg;

  localparam int ADDR_MAX_W = 6;   // element index field, enough for 64 elements
  localparam int ROOT_BITS  = 25;  // reciprocal root is below 2^25
  localparam int ROOT_BIT_W = 5;
  localparam int EPS_W      = 8;
  localparam int W_W        = 33;  // variance plus epsilon
  localparam int LIM_SHIFT  = 48;  // root limit is 2^48 / w
  localparam int RND_SHIFT  = 28;
  localparam int SAT_SHIFT  = 17;  // any |q| of 2^17 or more saturates
  localparam int Q_W        = 18;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [PADDR_W-1:0] REG_EPSILON_ADDR = 3'd0;
  localparam logic [EPS_W-1:0]   EPSILON_RESET    = 8'd1;

  typedef struct packed {
    logic signed [15:0] x_value;
    logic signed [15:0] scale_value;
    logic signed [15:0] shift_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] norm_value;
    logic               clipped;
    logic               last_flag;
  } out_item_t;

  typedef struct packed {
    logic                  load;
    logic                  rd_en;
    logic                  rd_last;
    logic                  out_pass;
    logic [ADDR_MAX_W-1:0] addr;
    logic                  var_load;
    logic                  var_step;
    logic                  var_phase;
    logic                  div_load;
    logic                  div_step;
    logic                  root_init;
    logic                  root_step;
    logic [ROOT_BIT_W-1:0] root_bit;
    logic                  clear;
  } cmd_t;

  typedef struct packed {
    logic pipe_idle;
  } status_t;

endpackage

### rtl/ln_ctrl.sv
`timescale 1ns / 1ps
// Layer normalisation sequencer: load, deviation, divide, root and output passes.
// Depends on ln_pkg.
module ln_ctrl #(
  parameter int VECTOR_LENGTH = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  ln_pkg::status_t status,
  output logic            busy,
  output ln_pkg::cmd_t    cmd
);

  localparam int LOGN      = $clog2(VECTOR_LENGTH);
  localparam int MAG_W     = 16 + LOGN;
  localparam int ACC_W     = 2 * MAG_W + LOGN;
  localparam int NDIG      = (ACC_W + 7) / 8;
  localparam int VAR_STEPS = 2 * NDIG;
  localparam int DIV_W     = ln_pkg::LIM_SHIFT + 1;
  localparam int MAX_A     = (DIV_W > VECTOR_LENGTH) ? DIV_W : VECTOR_LENGTH;
  localparam int MAX_B     = (MAX_A > VAR_STEPS) ? MAX_A : VAR_STEPS;
  localparam int MAX_C     = (MAX_B > ln_pkg::ROOT_BITS) ? MAX_B : ln_pkg::ROOT_BITS;
  localparam int CNT_W     = $clog2(MAX_C);

  localparam logic [CNT_W-1:0] LAST_ELEM = CNT_W'(VECTOR_LENGTH - 1);
  localparam logic [CNT_W-1:0] LAST_VAR  = CNT_W'(VAR_STEPS - 1);
  localparam logic [CNT_W-1:0] LAST_DIV  = CNT_W'(DIV_W - 1);
  localparam logic [CNT_W-1:0] LAST_ROOT = CNT_W'(ln_pkg::ROOT_BITS - 1);

  typedef enum logic [3:0] {
    S_LOAD, S_DEV, S_DEV_WAIT, S_VAR_LOAD, S_VAR_RUN, S_LIM_LOAD, S_LIM_RUN,
    S_ROOT_INIT, S_ROOT_RUN, S_OUT, S_OUT_WAIT
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;

  always_comb begin
    cmd      = '0;
    cmd.addr = ln_pkg::ADDR_MAX_W'(cnt);
    case (state)
      S_LOAD:      cmd.load = start;
      S_DEV: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_last = (cnt == LAST_ELEM);
      end
      S_VAR_LOAD:  cmd.var_load = 1'b1;
      S_VAR_RUN: begin
        cmd.var_step  = 1'b1;
        cmd.var_phase = cnt[0];
      end
      S_LIM_LOAD:  cmd.div_load = 1'b1;
      S_LIM_RUN:   cmd.div_step = 1'b1;
      S_ROOT_INIT: cmd.root_init = 1'b1;
      S_ROOT_RUN: begin
        cmd.root_step = 1'b1;
        cmd.root_bit  = ln_pkg::ROOT_BIT_W'(LAST_ROOT - cnt);
      end
      S_OUT: begin
        cmd.rd_en    = 1'b1;
        cmd.out_pass = 1'b1;
        cmd.rd_last  = (cnt == LAST_ELEM);
      end
      S_OUT_WAIT:  cmd.clear = status.pipe_idle;
      default:     cmd = '0;
    endcase
  end

  assign busy = (state != S_LOAD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cnt   <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (start) begin
            if (cnt == LAST_ELEM) begin
              cnt   <= '0;
              state <= S_DEV;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_DEV: begin
          if (cnt == LAST_ELEM) begin
            cnt   <= '0;
            state <= S_DEV_WAIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_DEV_WAIT: if (status.pipe_idle) state <= S_VAR_LOAD;
        S_VAR_LOAD: state <= S_VAR_RUN;
        S_VAR_RUN: begin
          if (cnt == LAST_VAR) begin
            cnt   <= '0;
            state <= S_LIM_LOAD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_LIM_LOAD: state <= S_LIM_RUN;
        S_LIM_RUN: begin
          if (cnt == LAST_DIV) begin
            cnt   <= '0;
            state <= S_ROOT_INIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_ROOT_INIT: state <= S_ROOT_RUN;
        S_ROOT_RUN: begin
          if (cnt == LAST_ROOT) begin
            cnt   <= '0;
            state <= S_OUT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_OUT: begin
          if (cnt == LAST_ELEM) begin
            cnt   <= '0;
            state <= S_OUT_WAIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_OUT_WAIT: if (status.pipe_idle) state <= S_LOAD;
        default: begin
          state <= S_LOAD;
          cnt   <= '0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.var_load |-> status.pipe_idle)
    else $error("variance divide loaded while element pipe still active");

  a_clear_to_load: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (state == S_LOAD) && (cnt == '0))
    else $error("vector end did not return to load with zero count");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.div_step && cmd.rd_en) && !(cmd.root_step && cmd.load))
    else $error("passes overlap");

  a_dev_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEV && cmd.rd_last) |=> (state == S_DEV_WAIT))
    else $error("deviation pass did not end after last element");
`endif

endmodule

### rtl/ln_datapath.sv
`timescale 1ns / 1ps
// Layer normalisation datapath: element store, sum, squared deviation pipe, byte-step
// variance divide, bit-serial root-limit divider, bitwise root and output pipe. Needs ln_pkg.
module ln_datapath #(
  parameter int VECTOR_LENGTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ln_pkg::cmd_t             cmd,
  input  ln_pkg::in_item_t         item,
  input  logic [ln_pkg::EPS_W-1:0] epsilon,
  output ln_pkg::status_t          status,
  output ln_pkg::out_item_t        result,
  output logic                     result_strobe
);

  localparam int LOGN   = $clog2(VECTOR_LENGTH);
  localparam int ADDR_W = LOGN;
  localparam int SUM_W  = 16 + LOGN;
  localparam int D_W    = 17 + LOGN;
  localparam int MAG_W  = 16 + LOGN;
  localparam int B_W    = ln_pkg::ROOT_BITS;
  localparam int PR_W   = MAG_W + B_W;
  localparam int ACC_W  = 2 * MAG_W + LOGN;
  localparam int DIV_W  = ln_pkg::LIM_SHIFT + 1;
  localparam int W_W    = ln_pkg::W_W;
  localparam int P3_W   = PR_W + 16;
  localparam int AF_W   = P3_W + 1 - ln_pkg::RND_SHIFT;
  localparam int A_W    = ln_pkg::SAT_SHIFT + LOGN;
  localparam int K      = A_W + LOGN + 1;
  localparam int RSQ_W  = 2 * B_W + 1;
  localparam int Q_W    = ln_pkg::Q_W;

  // variance divide by N^3: each quotient byte takes a quotient phase and a remainder phase, exact reciprocal per byte
  localparam longint NCUBE_L = longint'(VECTOR_LENGTH) * VECTOR_LENGTH * VECTOR_LENGTH;
  localparam int     RB      = $clog2(NCUBE_L);
  localparam int     NDIG    = (ACC_W + 7) / 8;
  localparam int     VN_W    = 8 * NDIG;
  localparam int     VX_W    = RB + 8;
  localparam int     VS      = 2 * RB + 8;
  localparam int     RCP_W   = RB + 10;
  localparam int     VP_W    = VX_W + RCP_W;

  localparam logic signed [D_W-1:0] N_S   = D_W'(VECTOR_LENGTH);
  localparam logic [K-1:0]     RECIP      =
    K'(((longint'(1) << K) + longint'(VECTOR_LENGTH) - 1) / longint'(VECTOR_LENGTH));
  localparam logic [VX_W-1:0]  N_CUBE     = VX_W'(NCUBE_L);
  localparam logic [RCP_W-1:0] RCP        =
    RCP_W'(((longint'(1) << VS) + NCUBE_L - 1) / NCUBE_L);
  localparam logic [P3_W:0]    ROUND_ADD  =
    (P3_W + 1)'(longint'(VECTOR_LENGTH) << (ln_pkg::RND_SHIFT - 1));
  localparam logic [AF_W-1:0]  SAT_LIM    =
    AF_W'(longint'(VECTOR_LENGTH) << ln_pkg::SAT_SHIFT);
  localparam logic [DIV_W-1:0] LIM_DVD    = DIV_W'(longint'(1) << ln_pkg::LIM_SHIFT);
  localparam logic [B_W-1:0]   ROOT_MAX   = '1;
  localparam logic [Q_W-1:0]   Q_SAT      = Q_W'(longint'(1) << ln_pkg::SAT_SHIFT);

  // element store
  ln_pkg::in_item_t mem [VECTOR_LENGTH];
  ln_pkg::in_item_t rd_q;

  always_ff @(posedge clk) begin
    if (cmd.load) mem[cmd.addr[ADDR_W-1:0]] <= item;
    if (cmd.rd_en) rd_q <= mem[cmd.addr[ADDR_W-1:0]];
  end

  logic signed [SUM_W-1:0] sum;
  logic [ACC_W-1:0]        acc;

  // pipeline valid, pass and last flags
  logic [5:0] v;
  logic [5:0] outp;
  logic [5:0] lst;

  // stage payloads
  logic [MAG_W-1:0]   dmag1;
  logic               neg1, neg2, neg3, neg4, neg5;
  logic [15:0]        gmag1, gmag2;
  logic signed [15:0] off1, off2, off3, off4, off5;
  logic [PR_W-1:0]    prod2;
  logic [P3_W-1:0]    p3;
  logic               sat4;
  logic [A_W-1:0]     alo4;
  logic [Q_W-1:0]     q5;

  // variance divide
  logic [VN_W-1:0] vnum;
  logic [RB-1:0]   vrem;
  logic [7:0]      qd;
  logic [W_W-1:0]  vq;
  logic [VX_W-1:0] vx;
  logic [VP_W-1:0] vprod;
  logic [VX_W-1:0] vsub;

  // divider and root
  logic [DIV_W-1:0] dvd;
  logic [W_W-1:0]   rem;
  logic [W_W-1:0]   dvs;
  logic [W_W-1:0]   w;
  logic [B_W-1:0]   r;
  logic [RSQ_W-2:0] rsq;

  // stage 1 logic
  logic signed [D_W-1:0] d_c;
  logic [D_W-1:0]        dabs_c;
  logic signed [16:0]    g_ext;
  logic [16:0]           gabs_c;

  always_comb begin
    d_c    = D_W'(rd_q.x_value) * N_S - D_W'(sum);
    dabs_c = d_c[D_W-1] ? D_W'(-d_c) : D_W'(d_c);
    g_ext  = 17'(rd_q.scale_value);
    gabs_c = g_ext[16] ? 17'(-g_ext) : 17'(g_ext);
  end

  logic [B_W-1:0] mul_b;
  assign mul_b = outp[1] ? r : B_W'(dmag1);

  logic [P3_W:0]   a_full;
  logic [AF_W-1:0] a_c;
  assign a_full = (P3_W + 1)'(p3) + ROUND_ADD;
  assign a_c    = a_full[P3_W:ln_pkg::RND_SHIFT];

  logic [A_W+K-1:0] qprod;
  assign qprod = (A_W + K)'(alo4) * (A_W + K)'(RECIP);

  logic signed [19:0] q_s, y_c;
  assign q_s = 20'({2'b00, q5});
  assign y_c = (neg5 ? -q_s : q_s) + 20'(off5);

  // variance byte step: running remainder with the next numerator byte
  assign vx    = {vrem, vnum[VN_W-1 -: 8]};
  assign vprod = VP_W'(vx) * VP_W'(RCP);
  assign vsub  = vx - VX_W'(qd) * N_CUBE;

  // divider step
  logic [W_W:0]   trial;
  logic           qbit;
  logic [W_W-1:0] w_next;
  assign trial  = {rem, dvd[DIV_W-1]};
  assign qbit   = (trial >= {1'b0, dvs});
  assign w_next = vq + W_W'(epsilon);

  // root step: (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
  logic [RSQ_W-1:0] tsq;
  assign tsq = RSQ_W'(rsq) + (RSQ_W'(r) << (cmd.root_bit + 1'b1))
             + (RSQ_W'(1) << {cmd.root_bit, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      v             <= '0;
      outp          <= '0;
      lst           <= '0;
      sum           <= '0;
      acc           <= '0;
      result_strobe <= 1'b0;
    end else begin
      v    <= {v[4:3] & outp[4:3], v[2:0], cmd.rd_en};
      outp <= {outp[4:0], cmd.out_pass};
      lst  <= {lst[4:0], cmd.rd_last};
      result_strobe <= v[5];
      if (cmd.clear) begin
        sum <= '0;
        acc <= '0;
      end else begin
        if (cmd.load) sum <= sum + SUM_W'(item.x_value);
        if (v[2] && !outp[2]) acc <= acc + ACC_W'(prod2);
      end
    end
  end

  // element pipe payload
  always_ff @(posedge clk) begin
    dmag1 <= dabs_c[MAG_W-1:0];
    gmag1 <= gabs_c[15:0];
    neg1  <= d_c[D_W-1] ^ rd_q.scale_value[15];
    off1  <= rd_q.shift_value;

    prod2 <= PR_W'(dmag1) * PR_W'(mul_b);
    gmag2 <= gmag1;
    neg2  <= neg1;
    off2  <= off1;

    p3   <= P3_W'(prod2) * P3_W'(gmag2);
    neg3 <= neg2;
    off3 <= off2;

    sat4 <= (a_c >= SAT_LIM);
    alo4 <= a_c[A_W-1:0];
    neg4 <= neg3;
    off4 <= off3;

    q5   <= sat4 ? Q_SAT : Q_W'(qprod[A_W+K-1:K]);
    neg5 <= neg4;
    off5 <= off4;

    if (y_c > 20'sd32767) begin
      result.norm_value <= 16'sh7FFF;
      result.clipped    <= 1'b1;
    end else if (y_c < -20'sd32768) begin
      result.norm_value <= -16'sh8000;
      result.clipped    <= 1'b1;
    end else begin
      result.norm_value <= y_c[15:0];
      result.clipped    <= 1'b0;
    end
    result.last_flag <= lst[5];
  end

  // variance: quotient byte in phase 0, remainder and shift in phase 1
  always_ff @(posedge clk) begin
    if (cmd.var_load) begin
      vnum <= VN_W'(acc);
      vrem <= '0;
    end else if (cmd.var_step) begin
      if (!cmd.var_phase) begin
        qd <= vprod[VS+7:VS];
      end else begin
        vrem <= vsub[RB-1:0];
        vq   <= {vq[W_W-9:0], qd};
        vnum <= vnum << 8;
      end
    end
  end

  // root-limit divider and root
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem <= '0;
      dvd <= LIM_DVD;
      dvs <= w_next;
      w   <= w_next;
    end else if (cmd.div_step) begin
      rem <= qbit ? W_W'(trial - {1'b0, dvs}) : W_W'(trial);
      dvd <= {dvd[DIV_W-2:0], qbit};
    end
    if (cmd.root_init) begin
      r   <= (w == '0) ? ROOT_MAX : '0;
      rsq <= '0;
    end else if (cmd.root_step && (w != '0) && (tsq <= RSQ_W'(dvd))) begin
      r   <= r | (B_W'(1) << cmd.root_bit);
      rsq <= tsq[RSQ_W-2:0];
    end
  end

  assign status.pipe_idle = (v == '0);

endmodule

### rtl/layer_normalization.sv
`timescale 1ns / 1ps
// Layer normalisation top: APB epsilon register, sequencer, datapath (ln_pkg, ln_ctrl, ln_datapath).
// One element transfer a cycle while busy is low; after the last of N elements busy stays high
// through the deviation pass, the variance divide (NDIG = 7 byte steps at N = 64), DIV_W = 49
// root-limit divide steps, 25 root steps, the output pass and its drain. Results stream out
// from the output pass, one a cycle; the receiver cannot stall them. Synchronous reset clears
// count, sum and epsilon (to 1); element store contents are undefined until written.
module layer_normalization #(
  parameter int VECTOR_LENGTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  // element transfers
  input  logic                           start,
  output logic                           busy,
  input  ln_pkg::in_item_t               item,
  // results
  output logic                           result_strobe,
  output ln_pkg::out_item_t              result,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ln_pkg::PADDR_W-1:0]     paddr,
  input  logic [ln_pkg::PDATA_W-1:0]     pwdata,
  output logic [ln_pkg::PDATA_W-1:0]     prdata,
  output logic                           pready
);

  logic [ln_pkg::EPS_W-1:0] epsilon;
  ln_pkg::cmd_t             cmd;
  ln_pkg::status_t          status;

  // APB: zero wait states, only the epsilon register decodes
  assign pready = 1'b1;
  assign prdata = (paddr == ln_pkg::REG_EPSILON_ADDR)
                ? ln_pkg::PDATA_W'(epsilon) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= ln_pkg::EPSILON_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr == ln_pkg::REG_EPSILON_ADDR)) begin
      epsilon <= pwdata[ln_pkg::EPS_W-1:0];
    end
  end

  // sequencer: counts elements, steps dividers and root, walks the store twice
  ln_ctrl #(
    .VECTOR_LENGTH(VECTOR_LENGTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .status(status),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath: store, sum, deviation and output pipes, dividers, root
  ln_datapath #(
    .VECTOR_LENGTH(VECTOR_LENGTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .epsilon      (epsilon),
    .status       (status),
    .result       (result),
    .result_strobe(result_strobe)
  );

endmodule

### verif/layer_normalization_test.sv
`timescale 1ns / 1ps
// Self-checking bench for layer_normalization: element transfers, result checks, APB epsilon.
// Depends on ln_pkg and the layer_normalization RTL.

// Holds the predicted normalised outputs and checks the result strobes against them.
class norm_scoreboard;
  localparam int N = 64;

  logic [7:0] eps;
  logic signed [15:0] act_mem [N];
  logic signed [15:0] gain_mem [N];
  logic signed [15:0] ofs_mem [N];
  int count;
  int signed sum;
  ln_pkg::out_item_t pending_q[$];
  int mismatches;

  function void clear();
    eps = ln_pkg::EPSILON_RESET;
    count = 0;
    sum = 0;
    pending_q.delete();
    mismatches = 0;
  endfunction

  // Largest r below 2^25 with r*r <= 2^48 / w.
  function longint unsigned recip_root(longint unsigned w);
    longint unsigned lim, r, t;
    r = 0;
    if (w == 0) return (64'd1 << 25) - 1;
    lim = (64'd1 << 48) / w;
    for (int b = 24; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= lim) r = t;
    end
    return r;
  endfunction

  // Store one element; on the last of the vector work out every result.
  function void note_element(ln_pkg::in_item_t it);
    longint unsigned sumsq, w, r, den, mag, q, dm, gm;
    longint signed d, y;
    ln_pkg::out_item_t res;
    if (count >= N) count = 0;
    act_mem[count] = it.x_value;
    gain_mem[count] = it.scale_value;
    ofs_mem[count] = it.shift_value;
    sum += it.x_value;
    count++;
    if (count < N) return;
    sumsq = 0;
    for (int i = 0; i < N; i++) begin
      d = N * longint'(act_mem[i]) - sum;
      dm = d < 0 ? -d : d;
      sumsq += dm * dm;
    end
    w = sumsq / (N * N * N) + eps;
    r = recip_root(w);
    den = 64'(N) << 28;
    for (int i = 0; i < N; i++) begin
      d = N * longint'(act_mem[i]) - sum;
      dm = d < 0 ? -d : d;
      gm = gain_mem[i] < 0 ? -longint'(gain_mem[i]) : gain_mem[i];
      mag = dm * r * gm;
      q = (mag + den / 2) / den;
      y = ((d < 0) != (gain_mem[i] < 0)) ? -longint'(q) : longint'(q);
      y += ofs_mem[i];
      res.clipped = 1'b0;
      if (y > 32767) begin
        y = 32767;
        res.clipped = 1'b1;
      end
      if (y < -32768) begin
        y = -32768;
        res.clipped = 1'b1;
      end
      res.norm_value = y[15:0];
      res.last_flag = (i == N - 1);
      pending_q.push_back(res);
    end
    count = 0;
    sum = 0;
  endfunction

  function void check_result(ln_pkg::out_item_t got);
    ln_pkg::out_item_t exp_r;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.norm_value !== exp_r.norm_value || got.clipped !== exp_r.clipped ||
        got.last_flag !== exp_r.last_flag) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected val %0d clip %b last %b, got val %0d clip %b last %b",
                 exp_r.norm_value, exp_r.clipped, exp_r.last_flag,
                 got.norm_value, got.clipped, got.last_flag);
    end
  endfunction
endclass

module layer_normalization_test;

  localparam int N = 64;
  localparam longint LIMIT = 2_000_000;
  localparam int DRAIN = 400;  // longer than a whole vector takes to pass through

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  ln_pkg::in_item_t item = '0;
  logic result_strobe;
  ln_pkg::out_item_t result;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ln_pkg::PADDR_W-1:0] paddr = '0;
  logic [ln_pkg::PDATA_W-1:0] pwdata = '0;
  logic [ln_pkg::PDATA_W-1:0] prdata;
  logic pready;

  norm_scoreboard sb;
  longint cycles = 0;

  always #5 clk = ~clk;

  layer_normalization #(.VECTOR_LENGTH(N)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result_strobe(result_strobe), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // results cannot be held off: every strobe is a transfer
  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_result(result);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Idle gap; start drops only when the gap is not empty.
  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    if (n > 0) start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // One element transfer; start stays high until the edge that takes it.
  task automatic send_element(ln_pkg::in_item_t it);
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    sb.note_element(it);
  endtask

  // APB write: setup then access cycle, pready always high.
  task automatic write_epsilon(logic [7:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ln_pkg::REG_EPSILON_ADDR;
    pwdata <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.eps = v;
  endtask

  // Wait for every expected result, then the tail of the pipe.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic ln_pkg::in_item_t rand_item(int style);
    ln_pkg::in_item_t it;
    it.scale_value = 16'($urandom);
    it.shift_value = 16'($urandom);
    case (style)
      0: it.x_value = 16'($urandom);
      1: it.x_value = 16'(int'($urandom_range(0, 255)) - 128);
      default: it.x_value = 16'h0100;
    endcase
    if (style == 1) it.scale_value = 16'(int'($urandom_range(0, 8191)) - 4096);
    if (style == 1) it.shift_value = 16'(int'($urandom_range(0, 2047)) - 1024);
    return it;
  endfunction

  initial begin
    ln_pkg::in_item_t it;
    int style;
    sb = new();
    sb.clear();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes with zero epsilon, so a constant vector hits the saturated root.
    write_epsilon(8'd0);
    for (int i = 0; i < N; i++) begin
      it.x_value = 16'sd77;
      it.scale_value = (i % 2) ? 16'sh7fff : 16'sh8000;
      it.shift_value = (i % 3 == 0) ? 16'sh7fff : ((i % 3 == 1) ? 16'sh8000 : 16'sd0);
      send_element(it);
    end
    drain();
    write_epsilon(8'd255);
    for (int i = 0; i < N; i++) begin
      it.x_value = (i % 2) ? 16'sh7fff : 16'sh8000;
      it.scale_value = (i % 4 < 2) ? 16'sh7fff : 16'sh8000;
      it.shift_value = (i % 4 == 0) ? 16'sh7fff : 16'sh8000;
      send_element(it);
      if (i % 7 == 0) gap();
    end
    drain();

    // Random vectors: a random epsilon, then zero epsilon with a constant lead-in.
    for (int v = 0; v < 2; v++) begin
      case (v)
        0: write_epsilon(8'($urandom));
        default: write_epsilon(8'd0);
      endcase
      style = $urandom_range(0, 1);
      for (int i = 0; i < N; i++) begin
        send_element(rand_item((v == 1 && i < 8) ? 2 : style));
        gap();
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### files.f
rtl/ln_pkg.sv
rtl/ln_ctrl.sv
rtl/ln_datapath.sv
rtl/layer_normalization.sv
verif/layer_normalization_test.sv
